// File: sv/linear_prime_sieve_assert.svh
// ---------------------------------------------------------------------------
// Linear prime sieve assertion macros
// Shorthand forms for the concurrent checks of the sieve engine.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PRIME_SIEVE_ASSERT_SVH
`define LINEAR_PRIME_SIEVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define LPS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lps_pkg.sv
// ---------------------------------------------------------------------------
// Linear prime sieve package
// Shared constants, controller states and the command and status bundles.
// ---------------------------------------------------------------------------
package lps_pkg;

  localparam int MAX_LIMIT_DEF   = 16384;
  localparam int PRIME_SLOTS_DEF = 2048;
  localparam int LIMIT_W         = 15;
  localparam int PRIME_W         = 14;
  localparam int FIRST_CANDIDATE = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_MAP,
    ST_QRD,
    ST_QWAIT,
    ST_MUL,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic eng_init;
    logic got_clr;
    logic map_rd;
    logic append;
    logic k_clr;
    logic k_inc;
    logic q_rd;
    logic mul;
    logic mark;
    logic cand_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cand_ge_limit;
    logic map_bit;
    logic list_full;
    logic count_zero;
    logic prod_ge_limit;
    logic div_done;
    logic div_zero;
    logic k_last;
    logic got;
    logic out_free;
  } status_t;

endpackage

// File: sv/lps_if.sv
// ---------------------------------------------------------------------------
// Linear prime sieve channels
// Request and response channels with valid and ready handshake.
// ---------------------------------------------------------------------------
interface lps_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lps_pkg::PRIME_W-1:0] prime_value;
  logic                        exhausted;

  modport source (output valid, output prime_value, output exhausted, input ready);
  modport sink   (input valid, input prime_value, input exhausted, output ready);
endinterface

// File: sv/lps_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lps_rem.sv
// ---------------------------------------------------------------------------
// Remainder unit
// Restoring division, one dividend bit per cycle; reports a zero remainder.
// ---------------------------------------------------------------------------
module lps_rem #(
  parameter int DW = 15,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic          rem_zero
);

  localparam int SW = $clog2(DW + 1);

  logic [DW-1:0] num;
  logic [VW-1:0] rem;
  logic [VW-1:0] den;
  logic [SW-1:0] cnt;
  logic          run;
  logic          done_q;
  logic [VW:0]   sh;
  logic [VW:0]   diff;
  logic [VW-1:0] rem_next;

  always_comb begin
    sh       = {rem, num[DW-1]};
    diff     = sh - {1'b0, den};
    rem_next = (sh >= {1'b0, den}) ? diff[VW-1:0] : sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= SW'(DW);
      end else if (run) begin
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (run) begin
      num <= num << 1;
      rem <= rem_next;
    end
  end

  assign done     = done_q;
  assign rem_zero = (rem == '0);

endmodule

// File: sv/lps_ctrl.sv
// ---------------------------------------------------------------------------
// Sieve controller
// Sequences clearing, candidate tests, marking and result delivery.
// ---------------------------------------------------------------------------
module lps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_restart,
  output logic             req_ready,
  input  lps_pkg::status_t st,
  output lps_pkg::cmd_t    cmd
);

  lps_pkg::state_t state;
  lps_pkg::state_t state_next;
  logic            pend;
  logic            pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lps_pkg::ST_CLEAR;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    case (state)
      lps_pkg::ST_CLEAR: begin
        if (st.clr_last) begin
          state_next = pend ? lps_pkg::ST_TEST : lps_pkg::ST_IDLE;
          pend_next  = 1'b0;
        end
      end
      lps_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_restart) begin
            state_next = lps_pkg::ST_CLEAR;
            pend_next  = 1'b1;
          end else begin
            state_next = lps_pkg::ST_TEST;
          end
        end
      end
      lps_pkg::ST_TEST: begin
        state_next = st.cand_ge_limit ? lps_pkg::ST_DONE : lps_pkg::ST_MAP;
      end
      lps_pkg::ST_MAP: begin
        if (!st.map_bit) begin
          state_next = st.list_full ? lps_pkg::ST_DONE : lps_pkg::ST_QRD;
        end else begin
          state_next = st.count_zero ? lps_pkg::ST_NEXT : lps_pkg::ST_QRD;
        end
      end
      lps_pkg::ST_QRD: begin
        state_next = lps_pkg::ST_QWAIT;
      end
      lps_pkg::ST_QWAIT: begin
        state_next = lps_pkg::ST_MUL;
      end
      lps_pkg::ST_MUL: begin
        state_next = st.prod_ge_limit ? lps_pkg::ST_NEXT : lps_pkg::ST_DIV;
      end
      lps_pkg::ST_DIV: begin
        if (st.div_done) begin
          state_next = (st.div_zero || st.k_last) ? lps_pkg::ST_NEXT : lps_pkg::ST_QRD;
        end
      end
      lps_pkg::ST_NEXT: begin
        state_next = st.got ? lps_pkg::ST_DONE : lps_pkg::ST_TEST;
      end
      lps_pkg::ST_DONE: begin
        if (st.out_free) begin
          state_next = lps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      lps_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      lps_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.got_clr  = 1'b1;
          cmd.eng_init = req_restart;
        end
      end
      lps_pkg::ST_TEST: begin
        cmd.map_rd = !st.cand_ge_limit;
      end
      lps_pkg::ST_MAP: begin
        cmd.append = !st.map_bit && !st.list_full;
        cmd.k_clr  = 1'b1;
      end
      lps_pkg::ST_QRD: begin
        cmd.q_rd = 1'b1;
      end
      lps_pkg::ST_QWAIT: begin
        cmd.mul = 1'b1;
      end
      lps_pkg::ST_MUL: begin
        cmd.mark = !st.prod_ge_limit;
      end
      lps_pkg::ST_DIV: begin
        cmd.k_inc = st.div_done && !st.div_zero && !st.k_last;
      end
      lps_pkg::ST_NEXT: begin
        cmd.cand_inc = 1'b1;
      end
      lps_pkg::ST_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/lps_dp.sv
// ---------------------------------------------------------------------------
// Sieve datapath
// Limit register, counters, composite bitmap, prime list, product and
// remainder units, and the response register.
// ---------------------------------------------------------------------------
module lps_dp #(
  parameter int MAX_LIMIT   = lps_pkg::MAX_LIMIT_DEF,
  parameter int PRIME_SLOTS = lps_pkg::PRIME_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lps_pkg::LIMIT_W-1:0] cfg_wdata,
  input  lps_pkg::cmd_t               cmd,
  output lps_pkg::status_t            st,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [lps_pkg::PRIME_W-1:0] prime_value,
  output logic                        exhausted
);

  localparam int AW = $clog2(MAX_LIMIT);
  localparam int CW = $clog2(MAX_LIMIT + 1);
  localparam int QW = AW;
  localparam int KW = $clog2(PRIME_SLOTS);
  localparam int NW = $clog2(PRIME_SLOTS + 1);
  localparam int PW = QW + CW;
  localparam int EW = (CW > lps_pkg::LIMIT_W) ? CW : lps_pkg::LIMIT_W;
  localparam int XW = lps_pkg::PRIME_W + QW;

  logic [lps_pkg::LIMIT_W-1:0] sieve_limit;
  logic [EW-1:0]               lim_ext;
  logic [CW-1:0]               lim_act;
  logic [CW-1:0]               candidate;
  logic [NW-1:0]               count;
  logic [NW-1:0]               k;
  logic [NW-1:0]               k_plus;
  logic [AW-1:0]               clr_addr;
  logic                        got;
  logic [QW-1:0]               found;
  logic [XW-1:0]               found_ext;
  logic [QW-1:0]               q;
  logic [PW-1:0]               prod;
  logic                        out_free;
  logic                        map_we;
  logic [AW-1:0]               map_waddr;
  logic                        map_rdata;
  logic [QW-1:0]               list_rdata;
  logic                        div_done;
  logic                        div_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= lps_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      sieve_limit <= cfg_wdata;
    end
  end

  always_comb begin
    lim_ext = EW'(sieve_limit);
    lim_act = (lim_ext > EW'(MAX_LIMIT)) ? CW'(MAX_LIMIT) : lim_ext[CW-1:0];
  end

  assign k_plus   = k + NW'(1);
  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate <= CW'(lps_pkg::FIRST_CANDIDATE);
      count     <= '0;
      clr_addr  <= '0;
      k         <= '0;
      got       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.eng_init) begin
        candidate <= CW'(lps_pkg::FIRST_CANDIDATE);
        count     <= '0;
        clr_addr  <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_addr <= st.clr_last ? '0 : clr_addr + AW'(1);
        end
        if (cmd.append) begin
          count <= count + NW'(1);
        end
        if (cmd.cand_inc) begin
          candidate <= candidate + CW'(1);
        end
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k_plus;
      end
      if (cmd.got_clr) begin
        got <= 1'b0;
      end else if (cmd.append) begin
        got <= 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign found_ext = {lps_pkg::PRIME_W'(0), found};

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      found <= candidate[QW-1:0];
    end
    if (cmd.mul) begin
      q    <= list_rdata;
      prod <= {CW'(0), list_rdata} * {QW'(0), candidate};
    end
    if (cmd.out_load) begin
      prime_value <= got ? found_ext[lps_pkg::PRIME_W-1:0] : '0;
      exhausted   <= !got;
    end
  end

  assign map_we    = cmd.clr_step || cmd.mark;
  assign map_waddr = cmd.clr_step ? clr_addr : prod[AW-1:0];

  lps_ram #(
    .WIDTH(1),
    .DEPTH(MAX_LIMIT)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(!cmd.clr_step),
    .re   (cmd.map_rd),
    .raddr(candidate[AW-1:0]),
    .rdata(map_rdata)
  );

  lps_ram #(
    .WIDTH(QW),
    .DEPTH(PRIME_SLOTS)
  ) u_list (
    .clk  (clk),
    .we   (cmd.append),
    .waddr(count[KW-1:0]),
    .wdata(candidate[QW-1:0]),
    .re   (cmd.q_rd),
    .raddr(k[KW-1:0]),
    .rdata(list_rdata)
  );

  lps_rem #(
    .DW(CW),
    .VW(QW)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mark),
    .dividend(candidate),
    .divisor (q),
    .done    (div_done),
    .rem_zero(div_zero)
  );

  always_comb begin
    st.clr_last      = (clr_addr == AW'(MAX_LIMIT - 1));
    st.cand_ge_limit = (candidate >= lim_act);
    st.map_bit       = map_rdata;
    st.list_full     = (count >= NW'(PRIME_SLOTS));
    st.count_zero    = (count == '0);
    st.prod_ge_limit = (prod >= PW'(lim_act));
    st.div_done      = div_done;
    st.div_zero      = div_zero;
    st.k_last        = (k_plus >= count);
    st.got           = got;
    st.out_free      = out_free;
  end

endmodule

// File: sv/linear_prime_sieve.sv
// ---------------------------------------------------------------------------
// Linear prime sieve
// Euler sieve engine that returns the next prime below the limit per request.
//
//   channel   direction  payload                      handshake
//   req       in         restart                      valid / ready
//   rsp       out        prime_value, exhausted       valid / ready
//   cfg       in         cfg_wdata (sieve limit)      cfg_we
//
// A request is accepted, then each candidate is tested against the bitmap; each
// stored prime tried on it is read and multiplied by it, and when that product is
// marked the bit-serial remainder unit divides the candidate by the prime. Reset
// and every restart request start a clearing pass over all MAX_LIMIT bitmap
// entries during which req.ready is low. A finished response waits in the output
// register until rsp.ready is high.
// ---------------------------------------------------------------------------
module linear_prime_sieve #(
  parameter int MAX_LIMIT   = lps_pkg::MAX_LIMIT_DEF,
  parameter int PRIME_SLOTS = lps_pkg::PRIME_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lps_pkg::LIMIT_W-1:0] cfg_wdata,
  lps_req_if.sink                     req,
  lps_rsp_if.source                   rsp
);

  lps_pkg::cmd_t    cmd;
  lps_pkg::status_t st;

  lps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_restart(req.restart),
    .req_ready  (req.ready),
    .st         (st),
    .cmd        (cmd)
  );

  lps_dp #(
    .MAX_LIMIT  (MAX_LIMIT),
    .PRIME_SLOTS(PRIME_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .prime_value(rsp.prime_value),
    .exhausted  (rsp.exhausted)
  );

endmodule

// File: sv/lps_checker.sv
// ---------------------------------------------------------------------------
// Linear prime sieve checker
// Port-level checks on responses, stalls and reset behavior.
// ---------------------------------------------------------------------------
`include "linear_prime_sieve_assert.svh"

module lps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [lps_pkg::PRIME_W-1:0] prime_value,
  input logic                        exhausted
);

  `LPS_ASSERT_IMP(a_exh_zero, clk, rst, rsp_valid && exhausted, prime_value == '0, "exhausted response carries a nonzero prime")
  `LPS_ASSERT_IMP(a_prime_min, clk, rst, rsp_valid && !exhausted, prime_value >= 2, "delivered prime is below two")
  `LPS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(prime_value) && $stable(exhausted), "stalled response changed")
  `LPS_ASSERT_NEXT(a_no_early, clk, rst, req_valid && req_ready, !$rose(rsp_valid), "response raised right after a request")
  `LPS_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !req_ready && !rsp_valid, "engine not quiet after reset")

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .prime_value(rsp.prime_value),
  .exhausted  (rsp.exhausted)
);
